// ----- src/rfm_pkg.sv -----
// Shared types, constants and codes of the reciprocal frequency meter.
package rfm_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_CLOCK_HZ      = 2'd0,
        CFG_TIMER_SPAN    = 2'd1,
        CFG_LOW_THRESHOLD = 2'd2
    } cfg_index_t;

    localparam logic [31:0] CLOCK_HZ_RESET      = 32'd24000000;
    localparam logic [16:0] TIMER_SPAN_RESET    = 17'd65536;
    localparam logic [31:0] LOW_THRESHOLD_RESET = 32'd70;

    // Depth of the queue between the event front end and the arithmetic back end.
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Linear correction (f * 10040 + 7166) / 10000; the divide by 10000 is a
    // multiply by ceil(2^45 / 10000) and a shift, exact for every 32-bit value.
    localparam logic [13:0] GAIN_NUM    = 14'd10040;
    localparam logic [31:0] GAIN_OFFSET = 32'd7166;
    localparam logic [31:0] RECIP_MUL   = 32'hD1B71759;
    localparam int          RECIP_SHIFT = 45;

    typedef struct packed {
        logic [31:0] clock_hz;
        logic [16:0] timer_span;
        logic [31:0] low_threshold;
    } rfm_cfg_t;

    // One pending capture: the wrapped capture difference and the rollovers seen.
    typedef struct packed {
        logic [31:0] diff;
        logic [31:0] count;
    } rfm_entry_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PERIOD,
        BK_START,
        BK_DIV,
        BK_SCALE,
        BK_RECIP,
        BK_CORR
    } bk_state_t;

endpackage

// ----- src/rfm_front.sv -----
// Event front end: counts rollovers and queues one entry per capture.
module rfm_front import rfm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // capture_value
    input  logic [1:0]  s_tuser,   // rollover_event, capture_event
    input  logic        q_full,
    output logic        q_push,
    output rfm_entry_t  q_push_data
);

    logic [31:0] count_reg, count_next;
    logic [15:0] last_reg, last_next;
    logic [31:0] count_eff;
    logic        accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        // A rollover in the same request is counted before the capture.
        count_eff         = count_reg + 32'(s_tuser[0]);
        count_next        = count_reg;
        last_next         = last_reg;
        q_push            = 1'b0;
        q_push_data.diff  = {16'd0, s_tdata} - {16'd0, last_reg};
        q_push_data.count = count_eff;
        if (accept)
        begin
            if (s_tuser[1])
            begin
                q_push     = 1'b1;
                count_next = '0;
                last_next  = s_tdata;
            end
            else
            begin
                count_next = count_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            last_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            last_reg  <= last_next;
        end
    end

endmodule

// ----- src/rfm_fifo.sv -----
// Short queue of pending captures between the front end and the back end.
module rfm_fifo import rfm_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  rfm_entry_t push_data,
    output logic       full,
    input  logic       pop,
    output rfm_entry_t pop_data,
    output logic       empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rfm_entry_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             do_push, do_pop;

    assign full     = (fill_reg == CNT_W'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ----- src/rfm_div.sv -----
// Restoring divider, one quotient bit per cycle.
module rfm_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    localparam int WIDTH = 32;
    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] quot_reg, rem_reg, div_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [WIDTH:0]   trial;
    logic             fits;

    assign trial    = {rem_reg, quot_reg[WIDTH-1]};
    assign fits     = (trial >= {1'b0, div_reg});
    assign done     = done_reg;
    assign quotient = quot_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[WIDTH-2:0], fits};
            rem_reg  <= fits ? WIDTH'(trial - {1'b0, div_reg}) : trial[WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- src/rfm_back.sv -----
// Arithmetic back end: period, quotient, linear correction and result register.
module rfm_back import rfm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  rfm_cfg_t    cfg,
    input  logic        q_empty,
    input  rfm_entry_t  q_pop_data,
    output logic        q_pop,
    output logic        div_start,
    output logic [31:0] div_divisor,
    input  logic        div_done,
    input  logic [31:0] div_quotient,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,
    output logic [0:0]  m_tuser
);

    bk_state_t   state_reg, state_next;
    rfm_entry_t  entry_reg, entry_next;
    logic [31:0] period_reg, period_next;
    logic [31:0] raw_reg, raw_next;
    logic        zero_reg, zero_next;
    logic [31:0] scaled_reg, scaled_next;
    logic [63:0] prod_reg, prod_next;
    logic        out_valid_reg, out_valid_next;
    logic [95:0] out_data_reg, out_data_next;
    logic        out_zero_reg, out_zero_next;

    logic [48:0] span_prod;
    logic [45:0] gain_prod;
    logic [31:0] offset_sum;
    logic [31:0] corr;

    assign span_prod   = entry_reg.count * cfg.timer_span;
    assign gain_prod   = raw_reg * GAIN_NUM;
    assign offset_sum  = scaled_reg + GAIN_OFFSET;
    assign div_divisor = period_reg;
    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = out_data_reg;
    assign m_tuser     = out_zero_reg;

    always_comb
    begin
        state_next     = state_reg;
        entry_next     = entry_reg;
        period_next    = period_reg;
        raw_next       = raw_reg;
        zero_next      = zero_reg;
        scaled_next    = scaled_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_zero_next  = out_zero_reg;
        q_pop          = 1'b0;
        div_start      = 1'b0;
        corr           = 32'(prod_reg[63:RECIP_SHIFT]);
        if (corr < cfg.low_threshold)
        begin
            corr = corr + 32'd1;
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    entry_next = q_pop_data;
                    state_next = BK_PERIOD;
                end
            end
            BK_PERIOD:
            begin
                period_next = entry_reg.diff + span_prod[31:0];
                state_next  = BK_START;
            end
            BK_START:
            begin
                zero_next = (period_reg == '0);
                if (period_reg == '0)
                begin
                    raw_next   = '0;
                    state_next = BK_SCALE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (div_done)
                begin
                    raw_next   = div_quotient;
                    state_next = BK_SCALE;
                end
            end
            BK_SCALE:
            begin
                scaled_next = gain_prod[31:0];
                state_next  = BK_RECIP;
            end
            BK_RECIP:
            begin
                prod_next  = offset_sum * RECIP_MUL;
                state_next = BK_CORR;
            end
            BK_CORR:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {corr, raw_reg, period_reg};
                    out_zero_next  = zero_reg;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg    <= entry_next;
        period_reg   <= period_next;
        raw_reg      <= raw_next;
        zero_reg     <= zero_next;
        scaled_reg   <= scaled_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
        out_zero_reg <= out_zero_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- src/reciprocal_frequency_meter_unit.sv -----
// Top level of the reciprocal frequency meter: configuration, front end, queue, back end.
//
// The slave stream carries one timer event per request: s_tuser[0] flags a timer
// rollover, s_tuser[1] flags a capture, and s_tdata holds the 16-bit capture value.
// A rollover-only request updates the rollover count and produces no result. Each
// capture produces one result on the master stream: m_tdata holds the period in
// ticks, the raw frequency (clock_hz / period) and the corrected frequency, and
// m_tuser[0] flags a zero period, for which the divide is skipped.
// The front end takes one request per cycle as long as the capture queue has room.
// The back end takes one capture at a time through its period, start, divide, scale,
// reciprocal and correction states; the 32-step restoring divider dominates, and a
// zero period skips the divider.
// Reset clears the rollover count, the previous capture, the queue and the result
// valid flag, and loads the configuration registers with their default values.
// If the receiver holds m_tready low, the result stays in the output register, the
// back end waits, the queue fills, and s_tready falls once it is full.
// Registers are written through cfg_we, cfg_addr and cfg_wdata; an unused index is
// ignored. Writes are meant for times when no capture is in flight.
module reciprocal_frequency_meter_unit import rfm_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // capture_value
    input  logic [1:0]  s_tuser,   // rollover_event, capture_event
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // period_ticks, raw_frequency, corrected_frequency
    output logic [0:0]  m_tuser,   // zero_period
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    rfm_cfg_t    cfg_reg;
    rfm_entry_t  push_data, pop_data;
    logic        q_push, q_pop, q_full, q_empty;
    logic        div_start, div_done;
    logic [31:0] div_divisor, div_quotient;

    // Configuration registers; writes to an index outside the list fall through.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clock_hz      <= CLOCK_HZ_RESET;
            cfg_reg.timer_span    <= TIMER_SPAN_RESET;
            cfg_reg.low_threshold <= LOW_THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_addr))
                CFG_CLOCK_HZ:      cfg_reg.clock_hz      <= cfg_wdata;
                CFG_TIMER_SPAN:    cfg_reg.timer_span    <= cfg_wdata[16:0];
                CFG_LOW_THRESHOLD: cfg_reg.low_threshold <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // The front end tracks rollovers and the previous capture at full request rate while the queue has room.
    rfm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_data (push_data)
    );

    // Pending captures wait here while the back end is busy or stalled.
    rfm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    // The divider is the long pole: one quotient bit per cycle.
    rfm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cfg_reg.clock_hz),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    rfm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_empty      (q_empty),
        .q_pop_data   (pop_data),
        .q_pop        (q_pop),
        .div_start    (div_start),
        .div_divisor  (div_divisor),
        .div_done     (div_done),
        .div_quotient (div_quotient),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

`ifndef ASSERT_OFF
    // A zero period never carries a nonzero quotient.
    a_zero_raw: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[63:32] == 32'd0)
        else $error("zero period with nonzero raw frequency");

    // The zero flag matches the reported period.
    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser[0] == (m_tdata[31:0] == 32'd0))
        else $error("zero period flag does not match period");

    // A raw frequency of zero corrects to zero or one.
    a_zero_corr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[63:32] == 32'd0 |-> m_tdata[95:64] <= 32'd1)
        else $error("corrected frequency out of range for zero raw frequency");
`endif

endmodule
